### rtl/egdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elias gamma / delta codec package
// Word types, status and kind codes, and small bit-search helpers shared by
// the codec modules.
// ----------------------------------------------------------------------------
package egdc_pkg;

  localparam int DATA_BITS = 64;
  localparam int LEN_BITS  = 7;

  // Item kind.
  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // Code selection held in the configuration register.
  localparam logic CODE_GAMMA = 1'b0;
  localparam logic CODE_DELTA = 1'b1;

  // Result status.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  typedef struct packed {
    logic                 kind;
    logic [DATA_BITS-1:0] word;
  } in_word_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] result_word;
    logic [LEN_BITS-1:0]  bit_length;
    logic [1:0]           status;
  } out_word_t;

  // Index of the highest set bit of a byte, 0 when the byte is empty.
  function automatic logic [2:0] msb8(input logic [7:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Index of the highest set bit of a 7-bit value, 0 when empty.
  function automatic logic [2:0] msb7(input logic [6:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

  // Mirror a word end for end, so that the lowest set bit becomes the highest.
  function automatic logic [DATA_BITS-1:0] bit_reverse(input logic [DATA_BITS-1:0] v);
    logic [DATA_BITS-1:0] r;
    for (int i = 0; i < DATA_BITS; i++) begin
      r[i] = v[DATA_BITS-1-i];
    end
    return r;
  endfunction

endpackage

### rtl/egdc_msb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leading one finder
// Gives the index of the highest set bit of a 64-bit word in two levels:
// first the highest non-empty byte, then the highest bit inside that byte.
// ----------------------------------------------------------------------------
module egdc_msb (
  input  logic [egdc_pkg::DATA_BITS-1:0] vec,
  output logic [5:0]                     idx
);
  import egdc_pkg::*;

  logic [7:0] byte_nz;
  logic [2:0] hi;
  logic [7:0] sel_byte;
  logic [2:0] lo;

  // One flag per byte, then pick the top non-empty byte and search inside it.
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      byte_nz[b] = |vec[b*8 +: 8];
    end
    hi       = msb8(byte_nz);
    sel_byte = vec[{hi, 3'b000} +: 8];
    lo       = msb8(sel_byte);
    idx      = {hi, lo};
  end

endmodule

### rtl/elias_gamma_delta_codec_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elias gamma / delta codec, top level
// Encodes a positive number into its gamma or delta code, or decodes a code
// that starts at bit 0 of a word, with the code chosen by a register.
// ----------------------------------------------------------------------------
// The codec takes one word per cycle while in_stall is low, and returns its result
// after acceptance through three register stages: a leading one search, length
// calculation with field extraction, and a final shift and assembly that
// also holds the output register. Back-pressure ripples stage by stage, so
// empty stages are filled while the output waits, and in_stall rises only
// when all three stages hold words. Errors (zero input, code longer than
// WORD_BITS) return a status with zero result and length. The code_type
// register should be written only while no words are in flight.
module elias_gamma_delta_codec_top #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  egdc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output egdc_pkg::out_word_t  out_data,
  input  logic                 cfg_write,
  input  logic                 cfg_data
);
  import egdc_pkg::*;

  localparam logic [LEN_BITS-1:0]  WB        = LEN_BITS'(WORD_BITS);
  localparam logic [DATA_BITS-1:0] WORD_MASK = (WORD_BITS >= DATA_BITS) ? '1 :
                                               ((64'd1 << WORD_BITS) - 64'd1);

  typedef struct packed {
    logic                 dec;
    logic                 delta;
    logic                 zero;
    logic [5:0]           pos;
    logic [DATA_BITS-1:0] word;
  } s1_t;

  typedef struct packed {
    logic                 dec;
    logic                 delta;
    logic [1:0]           status;
    logic [LEN_BITS-1:0]  len;
    logic [DATA_BITS-1:0] word;
    logic [5:0]           sh;
    logic [12:0]          head;
    logic [31:0]          g;
  } s2_t;

  logic      code_type;
  logic      v1, v2;
  s1_t       s1, s1_next;
  s2_t       s2, s2_next;
  out_word_t out_next;
  logic      ready1, ready2, ready3;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code_type <= CODE_GAMMA;
    end else if (cfg_write) begin
      code_type <= cfg_data;
    end
  end

  // Stage handshake: a stage loads when it is empty or its contents move on.
  assign ready3   = !out_valid || !out_stall;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // Stage 0: mask decode input, and find the top bit (encode) or, through a
  // mirrored word, the lowest set bit (decode).
  logic                 s0_dec;
  logic [DATA_BITS-1:0] s0_word;
  logic [DATA_BITS-1:0] s0_scan;
  logic [5:0]           s0_msb;

  always_comb begin
    s0_dec  = in_data.kind == KIND_DECODE;
    s0_word = s0_dec ? (in_data.word & WORD_MASK) : in_data.word;
    s0_scan = s0_dec ? bit_reverse(s0_word) : s0_word;
  end

  egdc_msb u_msb (
    .vec (s0_scan),
    .idx (s0_msb)
  );

  always_comb begin
    s1_next.dec   = s0_dec;
    s1_next.delta = code_type == CODE_DELTA;
    s1_next.zero  = s0_word == '0;
    s1_next.pos   = s0_dec ? ~s0_msb : s0_msb;
    s1_next.word  = s0_word;
  end

  // Stage 1: code lengths, range checks, and the gamma field when decoding.
  logic [DATA_BITS-1:0] e_mant;
  logic [6:0]           e_m;
  logic [2:0]           e_gl;
  logic [6:0]           e_mm;
  logic [12:0]          e_head;
  logic [3:0]           e_glen;
  logic [LEN_BITS-1:0]  e_len_d;
  logic [LEN_BITS-1:0]  odd_len;
  logic [4:0]           d_z5;
  logic [5:0]           d_sh;
  logic [31:0]          d_g;

  always_comb begin
    e_mant  = s1.word & ((64'd1 << s1.pos) - 64'd1);
    e_m     = 7'(s1.pos) + 7'd1;
    e_gl    = msb7(e_m);
    e_mm    = e_m & ~(7'd1 << e_gl);
    e_head  = 13'({e_mm, 1'b1}) << e_gl;
    e_glen  = {e_gl, 1'b1};
    e_len_d = 7'(e_glen) + 7'(s1.pos);
    // Twice the position plus one: gamma length for both directions.
    odd_len = {s1.pos, 1'b1};
    d_z5    = s1.pos[4:0];
    d_sh    = 6'(d_z5) + 6'd1;
    d_g     = (32'(s1.word >> d_sh) & ((32'd1 << d_z5) - 32'd1)) | (32'd1 << d_z5);

    s2_next.dec    = s1.dec;
    s2_next.delta  = s1.delta;
    s2_next.status = STATUS_OK;
    s2_next.len    = odd_len;
    s2_next.word   = s1.word;
    s2_next.sh     = '0;
    s2_next.head   = '0;
    s2_next.g      = d_g;

    if (s1.zero) begin
      s2_next.status = STATUS_ZERO;
    end else if (!s1.dec) begin
      s2_next.len = s1.delta ? e_len_d : odd_len;
      if (s2_next.len > WB) begin
        s2_next.status = STATUS_LONG;
      end
      if (s1.delta) begin
        s2_next.word = e_mant;
        s2_next.sh   = 6'(e_glen);
        s2_next.head = e_head;
      end else begin
        s2_next.word = {e_mant[DATA_BITS-2:0], 1'b1};
        s2_next.sh   = s1.pos;
      end
    end else begin
      if (odd_len > WB) begin
        s2_next.status = STATUS_LONG;
      end
      s2_next.word = s1.delta ? s1.word : {32'b0, d_g};
      s2_next.sh   = s1.delta ? odd_len[5:0] : 6'd0;
    end
  end

  // Stage 2: final shift and assembly, and the delta decode length check.
  logic [33:0]          d_sum;
  logic [5:0]           d_l6;

  always_comb begin
    d_sum = {2'b00, s2.g} + 34'(s2.sh) - 34'd1;
    d_l6  = 6'(s2.g - 32'd1);

    out_next.status      = s2.status;
    out_next.result_word = '0;
    out_next.bit_length  = '0;

    if (s2.status == STATUS_OK) begin
      if (s2.dec && s2.delta) begin
        if (d_sum > 34'(WB)) begin
          out_next.status = STATUS_LONG;
        end else begin
          out_next.result_word = ((s2.word >> s2.sh) & ((64'd1 << d_l6) - 64'd1)) |
                                 (64'd1 << d_l6);
          out_next.bit_length  = d_sum[LEN_BITS-1:0];
        end
      end else begin
        out_next.result_word = (s2.word << s2.sh) | 64'(s2.head);
        out_next.bit_length  = s2.len;
      end
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= in_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        out_valid <= v2;
      end
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk) begin
    if (ready1 && in_valid) begin
      s1 <= s1_next;
    end
    if (ready2 && v1) begin
      s2 <= s2_next;
    end
    if (ready3 && v2) begin
      out_data <= out_next;
    end
  end

  // A failed item carries neither a code nor a length.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_OK |->
      out_data.result_word == '0 && out_data.bit_length == '0)
    else $error("error result with nonzero payload");

  // A good item has a length between one and the word size.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_OK |->
      out_data.bit_length != '0 && out_data.bit_length <= WB)
    else $error("good result with bad length");

  // The input stalls only when every stage is full and the output is held.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && v2 && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
